### rtl/arx_iir_filter_step_macros.svh
// ----------------------------------------------------------------------------
// ARX IIR filter step assertion macros
// Concurrent check helpers for the filter step RTL; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ARX_IIR_FILTER_STEP_MACROS_SVH
`define ARX_IIR_FILTER_STEP_MACROS_SVH

// same-cycle implication
`define ARXIIR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ARXIIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/arxiir_pkg.sv
// ----------------------------------------------------------------------------
// ARX IIR filter package
// Tap counts, widths, cell control bundle and output rounding.
// ----------------------------------------------------------------------------
package arxiir_pkg;

  localparam int NUM_B_TAPS = 4;
  localparam int NUM_A_TAPS = 3;
  localparam int NUM_TAPS   = NUM_B_TAPS + NUM_A_TAPS;
  localparam int NUM_B_REGS = 4;
  localparam int NUM_A_REGS = 3;

  localparam int SMP_W     = 16;
  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 14;
  localparam int PROD_W    = SMP_W + COEF_W;
  localparam int ACC_W     = PROD_W + $clog2(NUM_TAPS) + 1;
  localparam int Q_W       = ACC_W - FRAC_BITS;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = $clog2(NUM_TAPS + 1);

  localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

  typedef struct packed {
    logic shift;
    logic coef_we;
    logic sub;
  } cell_ctrl_t;

  // round half up from Q.14, then saturate to the sample width
  function automatic logic signed [SMP_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    logic signed [Q_W-1:0]   q;
    t = acc + ACC_W'(1 << (FRAC_BITS - 1));
    q = t[ACC_W-1:FRAC_BITS];
    if (q > Q_W'(SMP_MAX)) begin
      round_sat = SMP_MAX;
    end else if (q < Q_W'(SMP_MIN)) begin
      round_sat = SMP_MIN;
    end else begin
      round_sat = q[SMP_W-1:0];
    end
  endfunction

endpackage

### rtl/arxiir_cell.sv
// ----------------------------------------------------------------------------
// ARX IIR tap cell
// Holds one history sample and its coefficient; adds or subtracts the tap
// product to the partial sum from its neighbor and registers it.
// ----------------------------------------------------------------------------
module arxiir_cell (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  arxiir_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [arxiir_pkg::COEF_W-1:0]   coef_data,
  input  logic signed [arxiir_pkg::SMP_W-1:0]    sample_in,
  output logic signed [arxiir_pkg::SMP_W-1:0]    sample_out,
  input  logic signed [arxiir_pkg::ACC_W-1:0]    psum_in,
  output logic signed [arxiir_pkg::ACC_W-1:0]    psum_out
);

  logic signed [arxiir_pkg::COEF_W-1:0] coef_r;
  logic signed [arxiir_pkg::SMP_W-1:0]  sample_r;
  logic signed [arxiir_pkg::PROD_W-1:0] prod;
  logic signed [arxiir_pkg::ACC_W-1:0]  term;
  logic signed [arxiir_pkg::ACC_W-1:0]  psum_r;
  logic signed [arxiir_pkg::ACC_W-1:0]  psum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r   <= '0;
      sample_r <= '0;
    end else begin
      if (ctrl.coef_we) begin
        coef_r <= coef_data;
      end
      if (ctrl.shift) begin
        sample_r <= sample_in;
      end
    end
  end

  assign prod     = coef_r * sample_r;
  assign term     = arxiir_pkg::ACC_W'(prod);
  assign psum_nxt = ctrl.sub ? (psum_in - term) : (psum_in + term);

  always_ff @(posedge clk) begin
    psum_r <= psum_nxt;
  end

  assign sample_out = sample_r;
  assign psum_out   = psum_r;

endmodule

### rtl/arx_iir_filter_step.sv
// ----------------------------------------------------------------------------
// ARX IIR filter step
// Direct-form-I ARX/IIR filter built as a row of tap cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one sample per transaction (valid/ready).
//   out_* : one saturated output per input, in order (valid/ready).
//   cfg_* : coefficient writes, index 0..3 = b_coef_0..3, 4..6 = a_coef_1..3;
//           cfg_ready is always high, write only while the filter is idle.
// Timing: an accepted sample shifts into the input history; the partial sum
//   then walks through the seven tap cells, one cell per cycle, and the
//   rounded result is registered on out_sample when the walk is done.
//   One sample is in work at a time; in_ready returns in the same cycle
//   that the result is registered (state back to idle), so a new sample
//   is taken only after the previous one has left the chain.
//   A new sample is taken while the previous result still waits on out_*.
// Stall: if out_ready is low when a result finishes, the chain holds it
//   until the output register frees; input stays blocked meanwhile.
// Reset: coefficients, both histories and out_valid clear.
// ----------------------------------------------------------------------------
`include "arx_iir_filter_step_macros.svh"

module arx_iir_filter_step (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [arxiir_pkg::SMP_W-1:0]       in_sample,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [arxiir_pkg::SMP_W-1:0]       out_sample,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [arxiir_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic signed [arxiir_pkg::COEF_W-1:0]      cfg_data
);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t                                state_r;
  logic [arxiir_pkg::CNT_W-1:0]          cnt_r;
  logic                                  out_valid_r;
  logic signed [arxiir_pkg::SMP_W-1:0]   out_sample_r;

  logic                                  in_fire;
  logic                                  done;
  logic                                  finish;
  logic signed [arxiir_pkg::SMP_W-1:0]   result;

  arxiir_pkg::cell_ctrl_t                ctrl [arxiir_pkg::NUM_TAPS];
  logic signed [arxiir_pkg::SMP_W-1:0]   smp_in  [arxiir_pkg::NUM_TAPS];
  logic signed [arxiir_pkg::SMP_W-1:0]   smp_out [arxiir_pkg::NUM_TAPS];
  logic signed [arxiir_pkg::ACC_W-1:0]   psum [arxiir_pkg::NUM_TAPS+1];

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign done      = (state_r == S_RUN) && (cnt_r == arxiir_pkg::CNT_W'(arxiir_pkg::NUM_TAPS));
  assign finish    = done && (!out_valid_r || out_ready);
  assign result    = arxiir_pkg::round_sat(psum[arxiir_pkg::NUM_TAPS]);
  assign cfg_ready = 1'b1;
  assign psum[0]   = '0;

  genvar k;
  generate
    for (k = 0; k < arxiir_pkg::NUM_TAPS; k++) begin : g_cell
      if (k < arxiir_pkg::NUM_B_TAPS) begin : g_b
        assign ctrl[k].shift = in_fire;
        assign ctrl[k].sub   = 1'b0;
        if (k < arxiir_pkg::NUM_B_REGS) begin : g_we
          assign ctrl[k].coef_we = cfg_valid && (cfg_index == arxiir_pkg::CFG_IDX_W'(k));
        end else begin : g_nowe
          assign ctrl[k].coef_we = 1'b0;
        end
        if (k == 0) begin : g_head
          assign smp_in[k] = in_sample;
        end else begin : g_link
          assign smp_in[k] = smp_out[k-1];
        end
      end else begin : g_a
        assign ctrl[k].shift = finish;
        assign ctrl[k].sub   = 1'b1;
        if ((k - arxiir_pkg::NUM_B_TAPS) < arxiir_pkg::NUM_A_REGS) begin : g_we
          assign ctrl[k].coef_we = cfg_valid && (cfg_index == arxiir_pkg::CFG_IDX_W'(
                                     arxiir_pkg::NUM_B_REGS + k - arxiir_pkg::NUM_B_TAPS));
        end else begin : g_nowe
          assign ctrl[k].coef_we = 1'b0;
        end
        if (k == arxiir_pkg::NUM_B_TAPS) begin : g_head
          assign smp_in[k] = result;
        end else begin : g_link
          assign smp_in[k] = smp_out[k-1];
        end
      end

      arxiir_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl[k]),
        .coef_data  (cfg_data),
        .sample_in  (smp_in[k]),
        .sample_out (smp_out[k]),
        .psum_in    (psum[k]),
        .psum_out   (psum[k+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_RUN;
            cnt_r   <= '0;
          end
        end
        S_RUN: begin
          if (!done) begin
            cnt_r <= cnt_r + 1'b1;
          end else if (finish) begin
            state_r      <= S_IDLE;
            out_valid_r  <= 1'b1;
            out_sample_r <= result;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  `ARXIIR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while busy")
  `ARXIIR_ASSERT_SAME(a_result_after_chain, $rose(out_valid), $past(done), "result before chain done")
  `ARXIIR_ASSERT_SAME(a_cnt_bound, state_r == S_RUN, cnt_r <= arxiir_pkg::CNT_W'(arxiir_pkg::NUM_TAPS), "tap counter overrun")

endmodule

### dv/arx_iir_filter_step_tb.sv
// ----------------------------------------------------------------------------
// ARX IIR filter step testbench
// Drives samples and coefficient writes into the filter under random
// backpressure and compares every output against a cycle-free fixed-point
// model of the direct-form-I recursion (round half up, 16-bit saturation).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arx_iir_filter_step_tb;

  localparam int SMP_W      = arxiir_pkg::SMP_W;
  localparam int COEF_W     = arxiir_pkg::COEF_W;
  localparam int CFG_IDX_W  = arxiir_pkg::CFG_IDX_W;
  localparam int FRAC_BITS  = arxiir_pkg::FRAC_BITS;
  localparam int NUM_B_TAPS = arxiir_pkg::NUM_B_TAPS;
  localparam int NUM_A_TAPS = arxiir_pkg::NUM_A_TAPS;
  localparam int NUM_B_REGS = arxiir_pkg::NUM_B_REGS;
  localparam int NUM_A_REGS = arxiir_pkg::NUM_A_REGS;
  localparam logic signed [SMP_W-1:0] SMP_MAX = arxiir_pkg::SMP_MAX;
  localparam logic signed [SMP_W-1:0] SMP_MIN = arxiir_pkg::SMP_MIN;

  localparam logic [CFG_IDX_W-1:0] REG_B_COEF_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_COEF_3 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 3'd7;
  localparam int NUM_REGS   = NUM_B_REGS + NUM_A_REGS;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 16;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [SMP_W-1:0]  in_sample = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [SMP_W-1:0]  out_sample;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic signed [COEF_W-1:0] cfg_data;

  logic signed [SMP_W-1:0]  sample_fifo [$];
  logic signed [SMP_W-1:0]  predicted_out [$];
  logic signed [COEF_W-1:0] coef_plan [NUM_REGS];

  logic signed [COEF_W-1:0] b_taps [NUM_B_TAPS];
  logic signed [COEF_W-1:0] a_taps [NUM_A_TAPS];
  logic signed [SMP_W-1:0]  u_hist [NUM_B_TAPS];
  logic signed [SMP_W-1:0]  y_hist [NUM_A_TAPS];

  int ties [8] = '{1, -1, 3, -3, 32767, -32768, 0, 16383};
  int pos_sat [8] = '{32767, 32767, 32767, -32768, -32768, -32768, 0, 1};
  int neg_sat [6] = '{32767, -32768, 32767, 0, -1, 5};

  logic in_taken;
  int   snd_idle_pct;
  int   rcv_idle_pct;
  int   errors = 0;
  int   cycle_count = 0;

  arx_iir_filter_step dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // shift in the new sample, form the Q.14 sum, round half up, saturate
  function automatic logic signed [SMP_W-1:0] filter_next(input logic signed [SMP_W-1:0] x);
    longint acc;
    longint q;
    logic signed [SMP_W-1:0] y;
    for (int i = NUM_B_TAPS - 1; i > 0; i--) u_hist[i] = u_hist[i-1];
    u_hist[0] = x;
    acc = 0;
    for (int i = 0; i < NUM_B_TAPS; i++) acc += longint'(b_taps[i]) * longint'(u_hist[i]);
    for (int i = 0; i < NUM_A_TAPS; i++) acc -= longint'(a_taps[i]) * longint'(y_hist[i]);
    q = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (q > longint'(SMP_MAX)) y = SMP_MAX;
    else if (q < longint'(SMP_MIN)) y = SMP_MIN;
    else y = q[SMP_W-1:0];
    for (int i = NUM_A_TAPS - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
    y_hist[0] = y;
    return y;
  endfunction

  function automatic void load_coef(input logic [CFG_IDX_W-1:0] idx,
                                    input logic signed [COEF_W-1:0] val);
    if (idx < NUM_B_REGS) begin
      if (idx < NUM_B_TAPS) b_taps[idx] = val;
    end else if (idx < NUM_REGS) begin
      if (idx - NUM_B_REGS < NUM_A_TAPS) a_taps[idx - NUM_B_REGS] = val;
    end
  endfunction

  function automatic logic signed [SMP_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? SMP_MAX : SMP_MIN;
      1, 2, 3: return SMP_W'(int'($urandom_range(512)) - 256);
      default: return SMP_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef(input int span);
    return COEF_W'(int'($urandom_range(2 * span)) - span);
  endfunction

  // monitor: model updates on config and input transactions, output checks
  always @(posedge clk) begin : monitor
    logic signed [SMP_W-1:0] want;
    if (!rst_n) begin
      in_taken <= 1'b0;
      predicted_out.delete();
      foreach (b_taps[i]) b_taps[i] = '0;
      foreach (a_taps[i]) a_taps[i] = '0;
      foreach (u_hist[i]) u_hist[i] = '0;
      foreach (y_hist[i]) y_hist[i] = '0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (cfg_valid && cfg_ready) load_coef(cfg_index, cfg_data);
      if (in_valid && in_ready) predicted_out.push_back(filter_next(in_sample));
      if (out_valid && out_ready) begin
        if (predicted_out.size() == 0) begin
          $error("out_sample: unexpected transaction, expected none, actual %0d", out_sample);
          errors++;
        end else begin
          want = predicted_out.pop_front();
          if (out_sample !== want) begin
            $error("out_sample: expected %0d, actual %0d", want, out_sample);
            errors++;
          end
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (sample_fifo.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_valid  <= 1'b1;
        in_sample <= sample_fifo.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL arx_iir_filter_step");
      $finish;
    end
  end

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (sample_fifo.size() != 0 || in_valid || predicted_out.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx,
                            input logic signed [COEF_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_coefs();
    for (int r = REG_B_COEF_0; r <= REG_A_COEF_3; r++) write_coef(CFG_IDX_W'(r), coef_plan[r]);
    write_coef(REG_UNUSED, COEF_W'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_plan(input logic signed [COEF_W-1:0] b, input logic signed [COEF_W-1:0] a);
    for (int i = 0; i < NUM_B_REGS; i++) coef_plan[i] = b;
    for (int i = NUM_B_REGS; i < NUM_REGS; i++) coef_plan[i] = a;
  endtask

  task automatic random_plan();
    case ($urandom_range(3))
      0: begin
        for (int i = 0; i < NUM_B_REGS; i++) coef_plan[i] = COEF_W'($urandom);
        for (int i = NUM_B_REGS; i < NUM_REGS; i++) coef_plan[i] = '0;
      end
      1: begin
        for (int i = 0; i < NUM_B_REGS; i++) coef_plan[i] = rand_coef(4096);
        coef_plan[NUM_B_REGS]     = rand_coef(8192);
        coef_plan[NUM_B_REGS + 1] = rand_coef(2048);
        coef_plan[NUM_B_REGS + 2] = rand_coef(2048);
      end
      2: begin
        coef_plan[0] = '0;
        coef_plan[1] = '0;
        coef_plan[2] = rand_coef(16384);
        coef_plan[3] = rand_coef(16384);
        coef_plan[NUM_B_REGS]     = rand_coef(8192);
        coef_plan[NUM_B_REGS + 1] = '0;
        coef_plan[NUM_B_REGS + 2] = '0;
      end
      default: begin
        for (int i = 0; i < NUM_REGS; i++) coef_plan[i] = COEF_W'($urandom);
      end
    endcase
  endtask

  task automatic queue_random(input int n);
    repeat (n) sample_fifo.push_back(pick_sample());
  endtask

  initial begin : sequencer
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    snd_idle_pct = 29;
    rcv_idle_pct = 71;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // half weight on the newest sample: exercises ties in rounding
    set_plan('0, '0);
    coef_plan[0] = 16'sd8192;
    program_coefs();
    foreach (ties[i]) sample_fifo.push_back(SMP_W'(ties[i]));
    wait_idle();

    // all taps at the extremes, positive feedback into saturation
    set_plan(SMP_MAX, SMP_MIN);
    program_coefs();
    foreach (pos_sat[i]) sample_fifo.push_back(SMP_W'(pos_sat[i]));
    wait_idle();

    set_plan(SMP_MIN, SMP_MAX);
    program_coefs();
    foreach (neg_sat[i]) sample_fifo.push_back(SMP_W'(neg_sat[i]));
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0:       begin snd_idle_pct = 29; rcv_idle_pct = 71; end
        1:       begin snd_idle_pct = 71; rcv_idle_pct = 29; end
        default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
      endcase
      random_plan();
      program_coefs();
      queue_random(55);
      // sender holds off until the filter has fully drained
      wait_idle();
      queue_random(55);
      wait_idle();
    end

    if (errors == 0) begin
      $display("PASS arx_iir_filter_step");
    end else begin
      $display("FAIL arx_iir_filter_step");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/arxiir_pkg.sv
rtl/arxiir_cell.sv
rtl/arx_iir_filter_step.sv
dv/arx_iir_filter_step_tb.sv
